[src/fmmn_pkg.sv]
// fmmn_pkg: shared constants, types and state codes for the frame min-max normalizer
// used by fmmn_ram users, fmmn_div and frame_min_max_normalizer
// no dependencies
package fmmn_pkg;

    localparam int FRAME_PIXELS = 768;
    localparam int ADDR_W       = $clog2(FRAME_PIXELS);
    localparam int CNT_W        = $clog2(FRAME_PIXELS + 1);
    localparam int SAMPLE_W     = 16;
    localparam int PIXEL_W      = 8;
    localparam int IDX_W        = 10;
    localparam int NUM_W        = 24;
    localparam int DIV_STEPS    = NUM_W;
    localparam int DCNT_W       = $clog2(DIV_STEPS + 1);

    localparam logic [CNT_W-1:0]           FRAME_FULL = CNT_W'(FRAME_PIXELS);
    localparam logic [CNT_W-1:0]           FRAME_LAST = CNT_W'(FRAME_PIXELS - 1);
    localparam logic [PIXEL_W-1:0]         SCALE_TOP  = 8'd254;
    localparam logic signed [SAMPLE_W-1:0] MIN_INIT   = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] MAX_INIT   = 16'sh8000;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EMIT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DIVIDE,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[src/frame_min_max_normalizer.sv]
// frame_min_max_normalizer: top level, frame store, running min/max and pixel sequencer
// depends on fmmn_pkg, fmmn_ram, fmmn_div
//
//   channel | signals                          | direction | notes
//   --------+----------------------------------+-----------+---------------------------
//   in      | in_valid in_ready mode sample    | to block  | load word or pixel request
//   out     | out_valid out_ready pixel        | from block| one result per served
//           | pixel_index last                 |           | pixel request
//
// a load request leaves the sequencer in idle, so the block stays ready for the next one
// a pixel request passes through scale, the 24-step restoring divider and hold;
// a flat frame skips the divider and goes from scale straight to hold
// the output register lets the next request be taken while a pixel waits;
// a second pixel waits in the hold state until the output register frees up
// rst_n clears counters, running min/max and handshake state; the frame store
// is not cleared and is fully rewritten by each frame
module frame_min_max_normalizer
    import fmmn_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       mode,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [PIXEL_W-1:0]         pixel,
    output logic [IDX_W-1:0]           pixel_index,
    output logic                       last
);

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0]           load_count_reg;
    logic [CNT_W-1:0]           emit_count_reg;
    logic signed [SAMPLE_W-1:0] min_reg;
    logic signed [SAMPLE_W-1:0] max_reg;
    logic                       flat_reg;
    logic                       out_valid_reg;
    logic [PIXEL_W-1:0]         pixel_reg;
    logic [IDX_W-1:0]           index_reg;
    logic                       last_reg;

    logic                in_fire;
    logic                load_go;
    logic                emit_go;
    logic                frame_full;
    logic                slot_free;
    logic                commit;
    logic                div_start;
    logic                is_last;
    logic [SAMPLE_W-1:0] store_rdata;
    logic [SAMPLE_W-1:0] range_w;
    logic [SAMPLE_W-1:0] offset_w;
    logic [NUM_W-1:0]    numer_w;
    logic [NUM_W-1:0]    quotient;
    div_status_t         div_stat;

    assign in_fire    = in_valid && in_ready;
    assign frame_full = (load_count_reg == FRAME_FULL);
    // loads past a full frame and early pixel requests are dropped silently
    assign load_go    = in_fire && (mode == MODE_LOAD) && !frame_full;
    assign emit_go    = in_fire && (mode == MODE_EMIT) && frame_full
                        && (emit_count_reg < FRAME_FULL);
    assign slot_free  = !out_valid_reg || out_ready;
    assign is_last    = (emit_count_reg == FRAME_LAST);

    // range and offset wrap cleanly into 16 unsigned bits since min <= word <= max
    assign range_w  = $unsigned(max_reg - min_reg);
    assign offset_w = store_rdata - $unsigned(min_reg);
    assign numer_w  = NUM_W'(offset_w) * NUM_W'(SCALE_TOP);

    // frame store: written by loads, read at the emit pointer every cycle
    fmmn_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (FRAME_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (load_go),
        .waddr (load_count_reg[ADDR_W-1:0]),
        .wdata ($unsigned(sample)),
        .raddr (emit_count_reg[ADDR_W-1:0]),
        .rdata (store_rdata)
    );

    fmmn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (numer_w),
        .denom    (range_w),
        .status   (div_stat),
        .quotient (quotient)
    );

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (emit_go)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                // store read data is valid here; flat frame skips the divide
                if (range_w != '0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // frame bookkeeping and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
            emit_count_reg <= '0;
            min_reg        <= MIN_INIT;
            max_reg        <= MAX_INIT;
            flat_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load_go)
            begin
                load_count_reg <= load_count_reg + CNT_W'(1);
                if (sample < min_reg)
                begin
                    min_reg <= sample;
                end
                if (sample > max_reg)
                begin
                    max_reg <= sample;
                end
            end

            if (state_reg == ST_SCALE)
            begin
                flat_reg <= (range_w == '0);
            end

            if (commit)
            begin
                out_valid_reg <= 1'b1;
                if (is_last)
                begin
                    // end of frame: back to the reset values for the next frame
                    load_count_reg <= '0;
                    emit_count_reg <= '0;
                    min_reg        <= MIN_INIT;
                    max_reg        <= MAX_INIT;
                end
                else
                begin
                    emit_count_reg <= emit_count_reg + CNT_W'(1);
                end
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            pixel_reg <= flat_reg ? '0 : PIXEL_W'(quotient);
            index_reg <= IDX_W'(emit_count_reg);
            last_reg  <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel       = pixel_reg;
    assign pixel_index = index_reg;
    assign last        = last_reg;

    // load counter never runs past the frame size
    assert property (@(posedge clk) disable iff (!rst_n)
        load_count_reg <= FRAME_FULL)
    else $error("load count beyond frame size");

    // pixels are only served from a complete frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_count_reg != '0) |-> frame_full)
    else $error("pixel pointer advanced on a partial frame");

    // a divider result only arrives while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIVIDE))
    else $error("divider finished outside the divide state");

    // a new pixel never overwrites one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (!out_valid_reg || out_ready))
    else $error("output register overwritten");

endmodule

[src/fmmn_ram.sv]
// fmmn_ram: generic single-write, single-read ram with registered read data
// no package dependencies
module fmmn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/fmmn_div.sv]
// fmmn_div: restoring divider, one quotient bit per cycle
// depends on fmmn_pkg
module fmmn_div
    import fmmn_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_W-1:0]    numer,
    input  logic [SAMPLE_W-1:0] denom,
    output div_status_t         status,
    output logic [NUM_W-1:0]    quotient
);

    logic                busy_reg;
    logic                done_reg;
    logic [DCNT_W-1:0]   cnt_reg;
    logic [SAMPLE_W-1:0] rem_reg;
    logic [SAMPLE_W-1:0] den_reg;
    logic [NUM_W-1:0]    quo_reg;

    logic [SAMPLE_W:0]   shifted;
    logic [SAMPLE_W+1:0] trial;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DCNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DCNT_W'(1);
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= denom;
            quo_reg <= numer;
        end
        else if (busy_reg)
        begin
            if (!trial[SAMPLE_W+1])
            begin
                rem_reg <= trial[SAMPLE_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[SAMPLE_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule
